// File: sv/agla_pkg.sv
`default_nettype none
package agla_pkg;

	localparam int QUERY_MAX_DEF  = 256;
	localparam int SCORE_BITS_DEF = 24;
	localparam int ROW_BITS_DEF   = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_REF  = 1'b1;

	localparam logic [2:0] REG_MATCH    = 3'd0;
	localparam logic [2:0] REG_MISMATCH = 3'd1;
	localparam logic [2:0] REG_DEL_OPEN = 3'd2;
	localparam logic [2:0] REG_INS_OPEN = 3'd3;
	localparam logic [2:0] REG_EXTEND   = 3'd4;

	typedef struct packed {
		logic signed [6:0] match;
		logic signed [6:0] mismatch;
		logic signed [7:0] del_open;
		logic signed [7:0] ins_open;
		logic signed [6:0] extend;
	} agla_cfg_t;

	localparam agla_cfg_t CFG_RESET = '{
		match:    7'sd2,
		mismatch: -7'sd3,
		del_open: -8'sd5,
		ins_open: -8'sd5,
		extend:   -7'sd2
	};

	typedef struct packed {
		logic valid;
		logic fresh;
		logic last;
	} agla_tok_ctrl_t;

endpackage
`default_nettype wire

// File: sv/agla_stream_if.sv
`default_nettype none
interface agla_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] base;
	logic       last;

	modport source (output valid, output opcode, output base, output last, input ready);
	modport sink (input valid, input opcode, input base, input last, output ready);
endinterface

interface agla_out_if;
	logic        valid;
	logic        ready;
	logic [22:0] best_score;
	logic [15:0] best_row;

	modport source (output valid, output best_score, output best_row, input ready);
	modport sink (input valid, input best_score, input best_row, output ready);
endinterface
`default_nettype wire

// File: sv/affine_gap_local_alignment.sv
// Channel   Role    Payload                    Moves when
// bases     sink    opcode, base, last         valid && ready
// scores    source  best_score, best_row       valid && ready
// wr_*      write   wr_index, wr_data          wr_en high
//
// Reference items enter the cell chain one per cycle while no result stalls; a result leaves
// once its last reference item has passed the cell registers and the result register.
// A query load waits until the chain holds no reference item.
// Reset restores register defaults and an empty query; no clearing pass.
// A stalled result freezes the whole chain and holds off new items.
`default_nettype none
module affine_gap_local_alignment #(
	parameter int QUERY_MAX  = agla_pkg::QUERY_MAX_DEF,
	parameter int SCORE_BITS = agla_pkg::SCORE_BITS_DEF,
	parameter int ROW_BITS   = agla_pkg::ROW_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	agla_in_if.sink    bases,
	agla_out_if.source scores,
	input  wire        wr_en,
	input  wire  [2:0] wr_index,
	input  wire  [7:0] wr_data
);
	import agla_pkg::*;

	localparam int QLEN_W = $clog2(QUERY_MAX + 1);
	localparam int IF_W   = $clog2(QUERY_MAX + 1) + 1;
	localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
	localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

	agla_cfg_t            cfg_q;
	logic [QLEN_W-1:0]    len_q;
	logic                 done_q;
	logic                 fresh_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [IF_W-1:0]      inflight_q;

	logic                 adv;
	logic                 acc;
	logic                 acc_load;
	logic                 acc_ref;
	logic                 load_write;
	logic [QLEN_W-1:0]    wr_slot;
	logic [ROW_BITS-1:0]  next_row;
	logic                 tail_exit;

	agla_tok_ctrl_t               tok_ctrl [0:QUERY_MAX];
	logic [7:0]                   tok_b    [0:QUERY_MAX];
	logic [ROW_BITS-1:0]          tok_row  [0:QUERY_MAX];
	logic signed [SCORE_BITS-1:0] tok_diag [0:QUERY_MAX];
	logic signed [SCORE_BITS-1:0] tok_left [0:QUERY_MAX];
	logic signed [SCORE_BITS-1:0] tok_hgap [0:QUERY_MAX];

	assign bases.ready = adv && ((bases.opcode == OP_REF) || (inflight_q == '0));
	assign acc         = bases.valid && bases.ready;
	assign acc_load    = acc && (bases.opcode == OP_LOAD);
	assign acc_ref     = acc && (bases.opcode == OP_REF);
	assign wr_slot     = done_q ? '0 : len_q;
	assign load_write  = acc_load && (done_q || (len_q < QLEN_W'(QUERY_MAX)));
	assign next_row    = fresh_q ? ROW_BITS'(1) :
	                     ((row_q == ROW_MAX) ? row_q : row_q + ROW_BITS'(1));
	assign tail_exit   = tok_ctrl[QUERY_MAX].valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MATCH:    cfg_q.match    <= wr_data[6:0];
				REG_MISMATCH: cfg_q.mismatch <= wr_data[6:0];
				REG_DEL_OPEN: cfg_q.del_open <= wr_data;
				REG_INS_OPEN: cfg_q.ins_open <= wr_data;
				REG_EXTEND:   cfg_q.extend   <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			done_q     <= 1'b0;
			fresh_q    <= 1'b1;
			row_q      <= '0;
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + IF_W'(acc_ref) - IF_W'(tail_exit);
			if (acc_load) begin
				fresh_q <= 1'b1;
				done_q  <= bases.last;
				if (done_q)
					len_q <= QLEN_W'(1);
				else if (len_q < QLEN_W'(QUERY_MAX))
					len_q <= len_q + QLEN_W'(1);
			end else if (acc_ref) begin
				fresh_q <= bases.last;
				row_q   <= next_row;
			end
		end
	end

	always_comb begin
		tok_ctrl[0].valid = acc_ref;
		tok_ctrl[0].fresh = fresh_q;
		tok_ctrl[0].last  = bases.last;
		tok_b[0]          = bases.base;
		tok_row[0]        = next_row;
		tok_diag[0]       = '0;
		tok_left[0]       = '0;
		tok_hgap[0]       = SMIN;
	end

	for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
		agla_cell #(
			.SCORE_BITS(SCORE_BITS),
			.ROW_BITS  (ROW_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.active   (len_q > QLEN_W'(k)),
			.load_we  (load_write && (wr_slot == QLEN_W'(k))),
			.load_base(bases.base),
			.cfg      (cfg_q),
			.ctrl_in  (tok_ctrl[k]),
			.b_in     (tok_b[k]),
			.row_in   (tok_row[k]),
			.diag_in  (tok_diag[k]),
			.left_in  (tok_left[k]),
			.hgap_in  (tok_hgap[k]),
			.ctrl_out (tok_ctrl[k+1]),
			.b_out    (tok_b[k+1]),
			.row_out  (tok_row[k+1]),
			.diag_out (tok_diag[k+1]),
			.left_out (tok_left[k+1]),
			.hgap_out (tok_hgap[k+1])
		);
	end

	agla_result #(
		.SCORE_BITS(SCORE_BITS),
		.ROW_BITS  (ROW_BITS)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.tail_ctrl (tok_ctrl[QUERY_MAX]),
		.tail_score(tok_left[QUERY_MAX]),
		.tail_row  (tok_row[QUERY_MAX]),
		.adv       (adv),
		.scores    (scores)
	);

`ifndef SYNTHESIS
	a_tail_counted: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ctrl[QUERY_MAX].valid |-> (inflight_q != '0))
		else $error("item at chain end not counted in flight");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= QLEN_W'(QUERY_MAX))
		else $error("query length beyond store");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(scores.valid && !scores.ready) |=> $stable(inflight_q))
		else $error("chain moved during result stall");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(scores.valid) |->
			$past(tok_ctrl[QUERY_MAX].valid && tok_ctrl[QUERY_MAX].last))
		else $error("result without final reference item");
`endif

endmodule
`default_nettype wire

// File: sv/agla_cell.sv
`default_nettype none
module agla_cell #(
	parameter int SCORE_BITS = 24,
	parameter int ROW_BITS   = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           adv,
	input  wire                           active,
	input  wire                           load_we,
	input  wire  [7:0]                    load_base,
	input  wire  agla_pkg::agla_cfg_t     cfg,
	input  wire  agla_pkg::agla_tok_ctrl_t ctrl_in,
	input  wire  [7:0]                    b_in,
	input  wire  [ROW_BITS-1:0]           row_in,
	input  wire  signed [SCORE_BITS-1:0]  diag_in,
	input  wire  signed [SCORE_BITS-1:0]  left_in,
	input  wire  signed [SCORE_BITS-1:0]  hgap_in,
	output agla_pkg::agla_tok_ctrl_t      ctrl_out,
	output logic [7:0]                    b_out,
	output logic [ROW_BITS-1:0]           row_out,
	output logic signed [SCORE_BITS-1:0]  diag_out,
	output logic signed [SCORE_BITS-1:0]  left_out,
	output logic signed [SCORE_BITS-1:0]  hgap_out
);
	import agla_pkg::*;

	localparam int SW = SCORE_BITS;
	localparam int EW = SCORE_BITS + 1;
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

	function automatic logic signed [SW-1:0] sat_add(
		input logic signed [SW-1:0] a,
		input logic signed [EW-1:0] c
	);
		logic signed [EW-1:0] s;
		s = {a[SW-1], a} + c;
		if (s[EW-1] != s[EW-2])
			return s[EW-1] ? SMIN : SMAX;
		return s[SW-1:0];
	endfunction

	logic [7:0]             qbase_q;
	logic signed [SW-1:0]   h_q;
	logic signed [SW-1:0]   e_q;

	logic signed [SW-1:0]   up;
	logic signed [SW-1:0]   vin;
	logic signed [EW-1:0]   sub;
	logic signed [SW-1:0]   d;
	logic signed [SW-1:0]   vo;
	logic signed [SW-1:0]   ve;
	logic signed [SW-1:0]   ho;
	logic signed [SW-1:0]   he;
	logic signed [SW-1:0]   v;
	logic signed [SW-1:0]   h;
	logic signed [SW-1:0]   c;

	always_comb begin
		up  = ctrl_in.fresh ? '0 : h_q;
		vin = ctrl_in.fresh ? SMIN : e_q;
		sub = (qbase_q == b_in) ? EW'(cfg.match) : EW'(cfg.mismatch);
		d   = sat_add(diag_in, sub);
		vo  = sat_add(up, EW'(cfg.del_open));
		ve  = sat_add(vin, EW'(cfg.extend));
		ho  = sat_add(left_in, EW'(cfg.ins_open));
		he  = sat_add(hgap_in, EW'(cfg.extend));
		v   = (vo > ve) ? vo : ve;
		h   = (ho > he) ? ho : he;
		c   = '0;
		if (d > c) c = d;
		if (v > c) c = v;
		if (h > c) c = h;
	end

	always_ff @(posedge clk) begin
		if (load_we)
			qbase_q <= load_base;
		if (adv && ctrl_in.valid && active) begin
			h_q <= c;
			e_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (adv) begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_out   <= b_in;
			row_out <= row_in;
			if (active) begin
				diag_out <= up;
				left_out <= c;
				hgap_out <= h;
			end else begin
				diag_out <= diag_in;
				left_out <= left_in;
				hgap_out <= hgap_in;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/agla_result.sv
`default_nettype none
module agla_result #(
	parameter int SCORE_BITS = 24,
	parameter int ROW_BITS   = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire agla_pkg::agla_tok_ctrl_t tail_ctrl,
	input  wire  signed [SCORE_BITS-1:0] tail_score,
	input  wire  [ROW_BITS-1:0]          tail_row,
	output logic                         adv,
	agla_out_if.source                   scores
);
	import agla_pkg::*;

	logic signed [SCORE_BITS-1:0] rb_q;
	logic [ROW_BITS-1:0]          rbrow_q;
	logic signed [SCORE_BITS-1:0] rb_eff;
	logic [ROW_BITS-1:0]          rbrow_eff;
	logic [SCORE_BITS-1:0]        bs;
	logic [ROW_BITS-1:0]          br;
	logic [SCORE_BITS+22:0]       bs_wide;
	logic [ROW_BITS+15:0]         br_wide;
	logic [22:0]                  bs_cap;

	assign adv = !scores.valid || scores.ready;

	always_comb begin
		rb_eff    = tail_ctrl.fresh ? '0 : rb_q;
		rbrow_eff = tail_ctrl.fresh ? '0 : rbrow_q;
		if (rb_eff > tail_score) begin
			bs = rb_eff;
			br = rbrow_eff;
		end else begin
			bs = tail_score;
			br = tail_row;
		end
		bs_wide = {23'b0, bs};
		br_wide = {16'b0, br};
		bs_cap  = (bs_wide > (SCORE_BITS + 23)'(23'h7FFFFF)) ? 23'h7FFFFF : bs_wide[22:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scores.valid <= 1'b0;
			rb_q         <= '0;
			rbrow_q      <= '0;
		end else if (adv) begin
			scores.valid <= tail_ctrl.valid && tail_ctrl.last;
			if (tail_ctrl.valid && !tail_ctrl.last) begin
				if (tail_score > rb_eff) begin
					rb_q    <= tail_score;
					rbrow_q <= tail_row;
				end else begin
					rb_q    <= rb_eff;
					rbrow_q <= rbrow_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_ctrl.valid && tail_ctrl.last) begin
			scores.best_score <= bs_cap;
			scores.best_row   <= br_wide[15:0];
		end
	end

endmodule
`default_nettype wire
